// ===== hdl/emaenv_pkg.sv =====
// ----------------------------------------------------------------------------
// EMA envelope tracker package
// Constants, register indexes and the configuration bundle shared by the
// filter and envelope tracker modules.
// ----------------------------------------------------------------------------
package emaenv_pkg;

  localparam int COEF_W     = 17;
  localparam int PERIOD_W   = 16;
  localparam int CFG_DATA_W = 17;
  localparam int CFG_ADDR_W = 3;

  // The shared multiplier consumes the coefficient one radix-64 digit per cycle.
  localparam int DIGIT_W     = 6;
  localparam int NUM_DIGITS  = (COEF_W + DIGIT_W - 1) / DIGIT_W;
  localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS);

  // Distance of a derived starting envelope from the first sample, and the
  // lowest envelope value, both in whole sample units.
  localparam int ENV_MARGIN = 5;
  localparam int ENV_FLOOR  = 1;

  localparam logic [COEF_W-1:0]   ETA_RST       = 17'd6554;
  localparam logic [COEF_W-1:0]   ETA_SLOW_RST  = 17'd655;
  localparam logic [COEF_W-1:0]   ETA_QUICK_RST = 17'd32768;
  localparam logic [PERIOD_W-1:0] PERIOD_RST    = 16'd100;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ETA       = 3'd0,
    REG_ETA_SLOW  = 3'd1,
    REG_ETA_QUICK = 3'd2,
    REG_PERIOD    = 3'd3,
    REG_INIT_MIN  = 3'd4,
    REG_INIT_MAX  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [COEF_W-1:0]   eta;
    logic [COEF_W-1:0]   eta_slow;
    logic [COEF_W-1:0]   eta_quick;
    logic [PERIOD_W-1:0] period;
  } cfg_t;

endpackage

// ===== hdl/emaenv_regs.sv =====
// ----------------------------------------------------------------------------
// EMA envelope tracker configuration registers
// Write-only register file holding the coefficients, the reading period and
// the starting envelope values.
// ----------------------------------------------------------------------------
module emaenv_regs import emaenv_pkg::*; #(
  parameter int INIT_W = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg,
  output logic [INIT_W-1:0]     init_min,
  output logic [INIT_W-1:0]     init_max
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.eta       <= ETA_RST;
      cfg.eta_slow  <= ETA_SLOW_RST;
      cfg.eta_quick <= ETA_QUICK_RST;
      cfg.period    <= PERIOD_RST;
      init_min      <= '1;
      init_max      <= '1;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_ETA:       cfg.eta       <= cfg_data[COEF_W-1:0];
        REG_ETA_SLOW:  cfg.eta_slow  <= cfg_data[COEF_W-1:0];
        REG_ETA_QUICK: cfg.eta_quick <= cfg_data[COEF_W-1:0];
        REG_PERIOD:    cfg.period    <= cfg_data[PERIOD_W-1:0];
        REG_INIT_MIN:  init_min      <= cfg_data[INIT_W-1:0];
        REG_INIT_MAX:  init_max      <= cfg_data[INIT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/emaenv_mac.sv =====
// ----------------------------------------------------------------------------
// EMA envelope tracker blend unit
// Shared iterative unit computing old + ((c * (target - old)) >>> FRAC_BITS)
// with the coefficient saturated to 1.0, one coefficient digit per cycle.
// ----------------------------------------------------------------------------
module emaenv_mac import emaenv_pkg::*; #(
  parameter int ENV_W     = 27,
  parameter int FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [COEF_W-1:0] coef,
  input  logic [ENV_W-1:0]  old_val,
  input  logic [ENV_W-1:0]  target,
  output logic              done,
  output logic [ENV_W-1:0]  result
);

  localparam int D_W    = ENV_W + 1;
  localparam int CPAD_W = NUM_DIGITS * DIGIT_W;
  localparam int P_W    = D_W + CPAD_W + 1;
  localparam int PART_W = D_W + DIGIT_W + 1;
  localparam int CW     = (FRAC_BITS + 1 > COEF_W) ? FRAC_BITS + 1 : COEF_W;
  localparam logic [CW-1:0] ONE_C = CW'(1) << FRAC_BITS;

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

  mstate_t                 state;
  logic signed [D_W-1:0]   diff;
  logic [CPAD_W-1:0]       cdig;
  logic signed [P_W-1:0]   acc;
  logic [DIGIT_CNT_W-1:0]  cnt;
  logic [ENV_W-1:0]        base;

  logic [COEF_W-1:0]       coef_sat;
  logic signed [D_W-1:0]   diff_in;
  logic signed [PART_W-1:0] part;
  logic signed [P_W-1:0]   acc_next;
  logic signed [P_W-1:0]   sum;

  // Blending as old plus a scaled difference gives the same floor as the
  // weighted sum of target and old, since that sum is never negative.
  always_comb begin
    coef_sat = (CW'(coef) > ONE_C) ? ONE_C[COEF_W-1:0] : coef;
    diff_in  = $signed({1'b0, target}) - $signed({1'b0, old_val});
    part     = diff * $signed({1'b0, cdig[CPAD_W-1 -: DIGIT_W]});
    acc_next = (acc <<< DIGIT_W) + P_W'(part);
    sum      = P_W'($signed({1'b0, base})) + (acc >>> FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        M_IDLE: begin
          if (start) begin
            diff  <= diff_in;
            cdig  <= CPAD_W'(coef_sat);
            acc   <= '0;
            cnt   <= DIGIT_CNT_W'(NUM_DIGITS - 1);
            base  <= old_val;
            state <= M_RUN;
          end
        end
        M_RUN: begin
          // Most significant digit first, so the partial sum shifts up each step.
          acc  <= acc_next;
          cdig <= cdig << DIGIT_W;
          cnt  <= cnt - 1'b1;
          if (cnt == '0) begin
            state <= M_FIN;
          end
        end
        M_FIN: begin
          result <= sum[ENV_W-1:0];
          done   <= 1'b1;
          state  <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/ema_filter_with_envelope_tracker.sv =====
// ----------------------------------------------------------------------------
// EMA filter with envelope tracker
// Exponential moving average of a converter sample with a slow/quick
// min/max envelope, read once every cfg.period ticks.
// ----------------------------------------------------------------------------
// One input transaction is one tick carrying a sample. The first tick after
// reset primes the filter and the starting envelopes and gives no result;
// a tick that does not reach the reading period also gives no result. A
// reading tick holds off the input while the filter, the minimum envelope
// and the maximum envelope are blended one after another in a single shared
// multiply unit (load, three radix-64 coefficient digits, finish and handoff
// per blend), and the result transaction is then offered on the output side,
// whose register lets a later tick be taken while the result still waits.
// Coefficients are Q1.FRAC_BITS and envelopes are unsigned fixed point with
// FRAC_BITS fraction bits; coefficients above 1.0 act as 1.0.
module ema_filter_with_envelope_tracker import emaenv_pkg::*; #(
  parameter int SAMPLE_BITS = 10,
  parameter int FRAC_BITS   = 16,
  localparam int ENV_W      = SAMPLE_BITS + 1 + FRAC_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SAMPLE_BITS-1:0] filtered,
  output logic [ENV_W-1:0]       env_min,
  output logic [ENV_W-1:0]       env_max
);

  localparam int INIT_W = SAMPLE_BITS + 1;
  localparam int IW     = SAMPLE_BITS + 2;
  localparam logic [ENV_W-1:0]     ONE_ENV  = ENV_W'(1) << FRAC_BITS;
  localparam logic signed [IW-1:0] MARGIN_S = IW'(ENV_MARGIN);
  localparam logic signed [IW-1:0] FLOOR_S  = IW'(ENV_FLOOR);

  typedef enum logic [2:0] {S_IDLE, S_FILT, S_MIN, S_MAX, S_OUT} state_t;

  cfg_t                   cfg;
  logic [INIT_W-1:0]      init_min;
  logic [INIT_W-1:0]      init_max;

  state_t                 state;
  logic                   primed;
  logic [PERIOD_W-1:0]    ticks;
  logic [SAMPLE_BITS-1:0] filt_val;
  logic [ENV_W-1:0]       min_env;
  logic [ENV_W-1:0]       max_env;
  logic                   out_valid_r;

  logic                   mac_start;
  logic [COEF_W-1:0]      mac_coef;
  logic [ENV_W-1:0]       mac_old;
  logic [ENV_W-1:0]       mac_target;
  logic                   mac_done;
  logic [ENV_W-1:0]       mac_result;

  logic [PERIOD_W-1:0]    ticks_next;
  logic                   reading;
  logic signed [IW-1:0]   lo;
  logic signed [IW-1:0]   hi;
  logic signed [IW-1:0]   lo_c;
  logic signed [IW-1:0]   hi_f;
  logic signed [IW-1:0]   hi_c;
  logic [ENV_W-1:0]       start_min;
  logic [ENV_W-1:0]       start_max;
  logic [SAMPLE_BITS-1:0] new_filt;
  logic [ENV_W-1:0]       v_new;
  logic [ENV_W-1:0]       v_reg;
  logic [ENV_W-1:0]       env_floor;

  emaenv_regs #(
    .INIT_W (INIT_W)
  ) u_regs (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg),
    .init_min (init_min),
    .init_max (init_max)
  );

  emaenv_mac #(
    .ENV_W     (ENV_W),
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk     (clk),
    .rst     (rst),
    .start   (mac_start),
    .coef    (mac_coef),
    .old_val (mac_old),
    .target  (mac_target),
    .done    (mac_done),
    .result  (mac_result)
  );

  assign in_ready  = (state == S_IDLE) && !rst;
  assign out_valid = out_valid_r && !rst;

  always_comb begin
    ticks_next = (ticks != '1) ? ticks + 1'b1 : ticks;
    reading    = (ticks_next >= cfg.period);

    // Starting envelopes are whole numbers; a negative register derives
    // them from the first sample.
    lo = init_min[INIT_W-1] ? $signed({2'b00, sample}) - MARGIN_S
                            : $signed({1'b0, init_min});
    hi = init_max[INIT_W-1] ? $signed({2'b00, sample}) + MARGIN_S
                            : $signed({1'b0, init_max});
    lo_c = (lo < FLOOR_S) ? FLOOR_S : lo;
    hi_f = (hi < FLOOR_S) ? FLOOR_S : hi;
    hi_c = (hi_f < lo_c) ? lo_c + MARGIN_S : hi_f;
    start_min = {lo_c[IW-2:0], {FRAC_BITS{1'b0}}};
    start_max = {hi_c[IW-2:0], {FRAC_BITS{1'b0}}};

    new_filt  = mac_result[SAMPLE_BITS-1:0];
    v_new     = {1'b0, new_filt, {FRAC_BITS{1'b0}}};
    v_reg     = {1'b0, filt_val, {FRAC_BITS{1'b0}}};
    env_floor = (mac_result < ONE_ENV) ? ONE_ENV : mac_result;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      primed      <= 1'b0;
      ticks       <= '0;
      filt_val    <= '0;
      min_env     <= '0;
      max_env     <= '0;
      mac_start   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mac_start <= 1'b0;
      // In S_OUT a new result may replace the one leaving in this cycle.
      if (out_valid_r && out_ready && (state != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (!primed) begin
              primed   <= 1'b1;
              ticks    <= '0;
              filt_val <= sample;
              min_env  <= start_min;
              max_env  <= start_max;
            end else if (reading) begin
              ticks      <= '0;
              mac_start  <= 1'b1;
              mac_coef   <= cfg.eta;
              mac_old    <= ENV_W'(filt_val);
              mac_target <= ENV_W'(sample);
              state      <= S_FILT;
            end else begin
              ticks <= ticks_next;
            end
          end
        end
        S_FILT: begin
          if (mac_done) begin
            filt_val   <= new_filt;
            mac_start  <= 1'b1;
            mac_coef   <= (v_new >= min_env) ? cfg.eta_slow : cfg.eta_quick;
            mac_old    <= min_env;
            mac_target <= v_new;
            state      <= S_MIN;
          end
        end
        S_MIN: begin
          if (mac_done) begin
            min_env    <= env_floor;
            mac_start  <= 1'b1;
            mac_coef   <= (v_reg <= max_env) ? cfg.eta_slow : cfg.eta_quick;
            mac_old    <= max_env;
            mac_target <= v_reg;
            state      <= S_MAX;
          end
        end
        S_MAX: begin
          if (mac_done) begin
            max_env <= env_floor;
            state   <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            filtered    <= filt_val;
            env_min     <= min_env;
            env_max     <= max_env;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/emaenv_chk.sv =====
// ----------------------------------------------------------------------------
// EMA envelope tracker port checker
// Concurrent checks on the top level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module emaenv_chk #(
  parameter int SAMPLE_BITS = 10,
  parameter int FRAC_BITS   = 16,
  localparam int ENV_W      = SAMPLE_BITS + 1 + FRAC_BITS
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] filtered,
  input logic [ENV_W-1:0]       env_min,
  input logic [ENV_W-1:0]       env_max
);

  localparam logic [ENV_W-1:0] ONE_ENV = ENV_W'(1) << FRAC_BITS;

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(filtered) &&
                                $stable(env_min) && $stable(env_max))
    else $error("result changed while stalled");

  // Both envelopes are floored at 1.0 in every result.
  a_env_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (env_min >= ONE_ENV) && (env_max >= ONE_ENV))
    else $error("envelope below 1.0");

  // A reading needs several blend passes, so no result follows a tick at once.
  a_no_instant: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("result appeared right after an input transaction");

  // Leaving reset, the block is ready for a tick and holds no result.
  a_reset_exit: assert property (@(posedge clk)
    $fell(rst) |-> in_ready && !out_valid)
    else $error("bad state after reset");

endmodule

bind ema_filter_with_envelope_tracker emaenv_chk #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .FRAC_BITS   (FRAC_BITS)
) u_emaenv_chk (.*);

// ===== tb/sv/ema_filter_with_envelope_tracker_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EMA filter with envelope tracker testbench
// Drives ticks through the valid/ready input, programs the coefficients, the
// period and the starting envelopes between phases, and checks every reading
// against a bit-accurate prediction of the filter and both envelopes.
// ----------------------------------------------------------------------------
module ema_filter_with_envelope_tracker_test;
  import emaenv_pkg::*;

  localparam int SAMPLE_W = 10;
  localparam int FRAC_W = 16;
  localparam int ENV_W = SAMPLE_W + 1 + FRAC_W;
  localparam int INIT_W = SAMPLE_W + 1;
  localparam longint UNITY = longint'(1) << FRAC_W;
  localparam int UNITY_I = 1 << FRAC_W;
  localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = '1;
  localparam logic [PERIOD_W-1:0] TICK_SAT = '1;
  localparam logic [INIT_W-1:0] START_DERIVE = '1;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 3'd7;
  localparam int SETTLE_CYCLES = 40;
  localparam int RANDOM_TICKS = 790;
  localparam int FINAL_TICKS = 60;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] filtered;
    logic [ENV_W-1:0] env_min;
    logic [ENV_W-1:0] env_max;
  } reading_t;

  class envelope_scoreboard;
    logic [COEF_W-1:0] eta, eta_slow, eta_quick;
    logic [PERIOD_W-1:0] period;
    logic [INIT_W-1:0] init_min, init_max;
    bit primed;
    logic [PERIOD_W-1:0] ticks;
    logic [SAMPLE_W-1:0] filt;
    logic [ENV_W-1:0] lo_env, hi_env;
    reading_t readings_due[$];
    int errors;

    function new();
      eta = ETA_RST;
      eta_slow = ETA_SLOW_RST;
      eta_quick = ETA_QUICK_RST;
      period = PERIOD_RST;
      init_min = START_DERIVE;
      init_max = START_DERIVE;
      primed = 0;
      ticks = '0;
      filt = '0;
      lo_env = '0;
      hi_env = '0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_ETA: eta = d[COEF_W-1:0];
        REG_ETA_SLOW: eta_slow = d[COEF_W-1:0];
        REG_ETA_QUICK: eta_quick = d[COEF_W-1:0];
        REG_PERIOD: period = d[PERIOD_W-1:0];
        REG_INIT_MIN: init_min = d[INIT_W-1:0];
        REG_INIT_MAX: init_max = d[INIT_W-1:0];
        default: ;
      endcase
    endfunction

    // Coefficients above 1.0 behave as 1.0.
    function logic [63:0] blend(logic [COEF_W-1:0] coef, logic [63:0] target,
                                logic [63:0] prior);
      logic [63:0] c;
      c = (coef > UNITY) ? UNITY : coef;
      return (c * target + (UNITY - c) * prior) >> FRAC_W;
    endfunction

    function void note_tick(logic [SAMPLE_W-1:0] s);
      longint lo, hi;
      logic [63:0] v, mn, mx;
      reading_t r;
      if (!primed) begin
        // A negative starting register derives the envelope from the sample.
        if (init_min[INIT_W-1]) lo = (longint'(s) - ENV_MARGIN) * UNITY;
        else lo = longint'(init_min[INIT_W-2:0]) * UNITY;
        if (init_max[INIT_W-1]) hi = (longint'(s) + ENV_MARGIN) * UNITY;
        else hi = longint'(init_max[INIT_W-2:0]) * UNITY;
        if (lo < UNITY) lo = UNITY;
        if (hi < UNITY) hi = UNITY;
        if (hi < lo) hi = lo + ENV_MARGIN * UNITY;
        primed = 1;
        ticks = '0;
        filt = s;
        lo_env = lo[ENV_W-1:0];
        hi_env = hi[ENV_W-1:0];
        return;
      end
      if (ticks != TICK_SAT) ticks++;
      if (ticks < period) return;
      ticks = '0;
      mn = blend(eta, 64'(s), 64'(filt));
      filt = mn[SAMPLE_W-1:0];
      v = 64'(filt) << FRAC_W;
      mn = blend((v >= lo_env) ? eta_slow : eta_quick, v, 64'(lo_env));
      mx = blend((v <= hi_env) ? eta_slow : eta_quick, v, 64'(hi_env));
      if (mn < UNITY) mn = UNITY;
      if (mx < UNITY) mx = UNITY;
      lo_env = mn[ENV_W-1:0];
      hi_env = mx[ENV_W-1:0];
      r.filtered = filt;
      r.env_min = lo_env;
      r.env_max = hi_env;
      readings_due.push_back(r);
    endfunction

    function void check_reading(logic [SAMPLE_W-1:0] f, logic [ENV_W-1:0] mn,
                                logic [ENV_W-1:0] mx);
      reading_t r;
      if (readings_due.size() == 0) begin
        $display("%0t: unexpected reading filtered %0d env_min %0d env_max %0d",
                 $time, f, mn, mx);
        errors++;
        return;
      end
      r = readings_due.pop_front();
      if (f !== r.filtered) begin
        $display("%0t: filtered expected %0d actual %0d", $time, r.filtered, f);
        errors++;
      end
      if (mn !== r.env_min) begin
        $display("%0t: env_min expected %0d actual %0d", $time, r.env_min, mn);
        errors++;
      end
      if (mx !== r.env_max) begin
        $display("%0t: env_max expected %0d actual %0d", $time, r.env_max, mx);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SAMPLE_W-1:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b1;
  logic [SAMPLE_W-1:0] filtered;
  logic [ENV_W-1:0] env_min;
  logic [ENV_W-1:0] env_max;

  envelope_scoreboard sb;
  bit gaps_on = 1;
  int stall_left = 0;
  int ticks_sent = 0;
  int cycles = 0;

  ema_filter_with_envelope_tracker #(
    .SAMPLE_BITS(SAMPLE_W),
    .FRAC_BITS(FRAC_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cfg_wr(cfg_wr),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .filtered(filtered),
    .env_min(env_min),
    .env_max(env_max)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_reading(filtered, env_min, env_max);
  end

  // Receiver stalls come in bursts, started at random while gaps are on.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_cfg(input logic [CFG_ADDR_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_wr <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= d;
    sb.write_reg(idx, d);
    @(negedge clk);
    cfg_wr <= 1'b0;
  endtask

  // Returns right after the accepting edge; the next call or settle() decides
  // what valid does at the following falling edge.
  task automatic send_tick(input logic [SAMPLE_W-1:0] s);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_tick(s);
    ticks_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.readings_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_coef();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CFG_DATA_W'(UNITY);
      2: return CFG_DATA_W'($urandom_range(UNITY_I + 1, (1 << COEF_W) - 1));
      3: return CFG_DATA_W'($urandom_range(1, 255));
      default: return CFG_DATA_W'($urandom_range(0, UNITY_I));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_period();
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom());
    case ($urandom_range(0, 9))
      0: d[PERIOD_W-1:0] = TICK_SAT;
      1, 2: d[PERIOD_W-1:0] = PERIOD_W'($urandom_range(4, 15));
      default: d[PERIOD_W-1:0] = PERIOD_W'($urandom_range(0, 3));
    endcase
    return d;
  endfunction

  // Upper data bits are random: only the low bits of the register count.
  function automatic logic [CFG_DATA_W-1:0] pick_start();
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom());
    case ($urandom_range(0, 5))
      0: d[INIT_W-1:0] = START_DERIVE;
      1: d[INIT_W-1:0] = {1'b1, SAMPLE_W'($urandom())};
      2: d[INIT_W-1:0] = '0;
      3: d[INIT_W-1:0] = {1'b0, SAMPLE_TOP};
      default: d[INIT_W-1:0] = INIT_W'($urandom_range(0, 1023));
    endcase
    return d;
  endfunction

  task automatic random_config();
    write_cfg(REG_ETA, pick_coef());
    write_cfg(REG_ETA_SLOW, pick_coef());
    write_cfg(REG_ETA_QUICK, pick_coef());
    write_cfg(REG_PERIOD, pick_period());
    write_cfg(REG_INIT_MIN, pick_start());
    write_cfg(REG_INIT_MAX, pick_start());
    if ($urandom_range(0, 3) == 0)
      write_cfg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                CFG_DATA_W'($urandom()));
  endtask

  // A slow walk keeps the filtered value inside the envelope, where the slow
  // coefficient applies; the other mode jumps around and hits the extremes.
  function automatic logic [SAMPLE_W-1:0] next_sample(input bit walk, inout int level);
    if (walk) begin
      level = level + int'($urandom_range(0, 16)) - 8;
      if (level < 0) level = 0;
      if (level > 1023) level = 1023;
      return SAMPLE_W'(level);
    end
    case ($urandom_range(0, 7))
      0: return '0;
      1: return SAMPLE_TOP;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  initial begin
    logic [SAMPLE_W-1:0] first;
    int phase_len, pause_at, level, phase_no;
    bit walk;
    sb = new();
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Full coefficient: the filter follows the sample and the envelope jumps
    // to it when outside, while the inside coefficient of zero holds it.
    write_cfg(REG_ETA, CFG_DATA_W'(UNITY));
    write_cfg(REG_ETA_SLOW, '0);
    write_cfg(REG_ETA_QUICK, CFG_DATA_W'(UNITY));
    write_cfg(REG_PERIOD, '0);
    write_cfg(REG_INIT_MIN, pick_start());
    write_cfg(REG_INIT_MAX, pick_start());
    write_cfg(REG_SPARE_A, CFG_DATA_W'($urandom()));
    write_cfg(REG_SPARE_B, CFG_DATA_W'($urandom()));
    case ($urandom_range(0, 3))
      0: first = '0;
      1: first = SAMPLE_W'(3);
      2: first = SAMPLE_TOP;
      default: first = SAMPLE_W'($urandom());
    endcase
    send_tick(first);
    send_tick(SAMPLE_TOP);
    send_tick('0);
    send_tick(SAMPLE_TOP);
    send_tick(SAMPLE_W'(512));
    send_tick('0);

    // Zero filter coefficient and an inside coefficient above 1.0.
    settle();
    write_cfg(REG_ETA, '0);
    write_cfg(REG_ETA_SLOW, '1);
    write_cfg(REG_ETA_QUICK, '0);
    write_cfg(REG_PERIOD, CFG_DATA_W'(1));
    write_cfg(REG_INIT_MIN, START_DERIVE);
    write_cfg(REG_INIT_MAX, SAMPLE_TOP);
    send_tick(SAMPLE_TOP);
    send_tick('0);
    send_tick(SAMPLE_W'(700));
    send_tick(SAMPLE_W'(1));
    send_tick(SAMPLE_TOP);
    send_tick('0);

    // Longest period gives no readings; shortening it afterwards makes the
    // next tick read at once since the count already exceeds the new period.
    settle();
    write_cfg(REG_ETA, CFG_DATA_W'(1));
    write_cfg(REG_ETA_SLOW, CFG_DATA_W'(UNITY - 1));
    write_cfg(REG_ETA_QUICK, CFG_DATA_W'(UNITY + 1));
    write_cfg(REG_PERIOD, TICK_SAT);
    repeat (4) send_tick(SAMPLE_W'($urandom()));
    settle();
    write_cfg(REG_PERIOD, CFG_DATA_W'(3));
    repeat (3) send_tick(SAMPLE_TOP);

    phase_no = 0;
    while (ticks_sent < RANDOM_TICKS) begin
      settle();
      random_config();
      phase_len = $urandom_range(30, 70);
      walk = 1'($urandom_range(0, 1));
      level = $urandom_range(0, 1023);
      pause_at = (phase_no == 0 || $urandom_range(0, 3) == 0) ? phase_len / 2 : -1;
      for (int i = 0; i < phase_len; i++) begin
        if (i == pause_at) settle();
        send_tick(next_sample(walk, level));
      end
      phase_no++;
    end

    // Closing stretch at full rate on both sides.
    settle();
    gaps_on = 0;
    random_config();
    walk = 1'($urandom_range(0, 1));
    level = $urandom_range(0, 1023);
    repeat (FINAL_TICKS) send_tick(next_sample(walk, level));

    settle();
    if (sb.errors == 0 && sb.readings_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
